[rtl/core/csr_sparse_row_dot_sddmm_macros.svh]
// Assertion helpers for the checker file csrsd_chk.
// Each expects i_clk and i_rst_n in scope.
`ifndef CSR_SPARSE_ROW_DOT_SDDMM_MACROS_SVH
`define CSR_SPARSE_ROW_DOT_SDDMM_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CSRSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CSRSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/csrsd_pkg.sv]
`timescale 1ns / 1ps

package csrsd_pkg;

    // Field widths of the input and result words
    localparam int CMD_W  = 3;
    localparam int SLOT_W = 11;
    localparam int COL_W  = 10;
    localparam int VAL_W  = 16;
    localparam int RS_W   = 11;
    localparam int ROW_W  = 6;
    localparam int ACC_W  = 40;
    localparam int PROD_W = 2 * VAL_W;

    // One stored nonzero: column index over value
    localparam int ENTRY_W = COL_W + VAL_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_L_ENTRY = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_L_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_M_ENTRY = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOAD_M_START = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY        = 3'd4;

    // Accumulator limits
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [SLOT_W-1:0]        slot;
        logic [COL_W-1:0]         column;
        logic signed [VAL_W-1:0]  value;
        logic [RS_W-1:0]          row_start;
        logic [ROW_W-1:0]         row_p;
        logic [ROW_W-1:0]         row_q;
    } t_in_word;

    typedef struct packed {
        logic signed [ACC_W-1:0]  dot_product;
        logic                     saturated;
    } t_out_word;

    // Merge walker to multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic fire;
    } t_mac_ctl;

endpackage

[rtl/core/csrsd_if.sv]
`timescale 1ns / 1ps

// Command word channel
interface csrsd_in_if;
    logic                 valid;
    logic                 ready;
    csrsd_pkg::t_in_word  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Result word channel
interface csrsd_out_if;
    logic                 valid;
    logic                 ready;
    csrsd_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/csrsd_ram.sv]
`timescale 1ns / 1ps

module csrsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/csrsd_mac.sv]
`timescale 1ns / 1ps

module csrsd_mac (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  csrsd_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [csrsd_pkg::VAL_W-1:0]     i_l_val,
    input  logic signed [csrsd_pkg::VAL_W-1:0]     i_m_val,
    output logic signed [csrsd_pkg::ACC_W-1:0]     o_acc,
    output logic                                   o_sat
);

    localparam int AW = csrsd_pkg::ACC_W;
    localparam int PW = csrsd_pkg::PROD_W;

    logic                 r_prod_valid;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;
    logic                 r_sat;

    logic signed [PW-1:0] prod;
    logic        [AW:0]   sum;
    logic                 ovf;
    logic signed [AW-1:0] n_acc;

    assign prod = i_l_val * i_m_val;

    // Add with one guard bit, clip on overflow
    always_comb begin
        sum   = {r_acc[AW-1], r_acc} + {{(AW + 1 - PW){r_prod[PW-1]}}, r_prod};
        ovf   = sum[AW] != sum[AW-1];
        n_acc = ovf ? (sum[AW] ? csrsd_pkg::ACC_MIN : csrsd_pkg::ACC_MAX)
                    : sum[AW-1:0];
    end

    // Register the product of a matched pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= i_ctl.fire;
        end
        if (i_ctl.fire) begin
            r_prod <= prod;
        end
    end

    // Accumulate, clear at the start of a query
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else if (i_ctl.clear) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else if (r_prod_valid) begin
            r_acc <= n_acc;
            r_sat <= r_sat | ovf;
        end
    end

    assign o_acc = r_acc;
    assign o_sat = r_sat;

endmodule

[rtl/core/csrsd_walk.sv]
`timescale 1ns / 1ps

module csrsd_walk #(
    parameter int MAX_ROWS     = 64,
    parameter int MAX_NONZEROS = 1024,
    localparam int AW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1,
    localparam int RW = $clog2(MAX_ROWS + 1),
    localparam int PW = $clog2(MAX_NONZEROS + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [csrsd_pkg::ROW_W-1:0]     i_row_p,
    input  logic [csrsd_pkg::ROW_W-1:0]     i_row_q,
    input  logic [csrsd_pkg::RS_W-1:0]      i_l_rs,
    input  logic [csrsd_pkg::RS_W-1:0]      i_m_rs,
    input  logic [csrsd_pkg::COL_W-1:0]     i_l_col,
    input  logic [csrsd_pkg::COL_W-1:0]     i_m_col,
    input  logic                            i_out_free,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [RW-1:0]                   o_l_rs_addr,
    output logic [RW-1:0]                   o_m_rs_addr,
    output logic [AW-1:0]                   o_l_ent_addr,
    output logic [AW-1:0]                   o_m_ent_addr,
    output csrsd_pkg::t_mac_ctl             o_mac
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RS0  = 3'd1;
    localparam logic [2:0] ST_RS1  = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]    r_state, n_state;
    logic          r_p_ok, n_p_ok;
    logic          r_q_ok, n_q_ok;
    logic [RW-1:0] r_p1, n_p1;
    logic [RW-1:0] r_q1, n_q1;
    logic [PW-1:0] r_li, n_li;
    logic [PW-1:0] r_lend, n_lend;
    logic [PW-1:0] r_mi, n_mi;
    logic [PW-1:0] r_mend, n_mend;

    logic p_ok, q_ok, run, col_eq, col_lt;

    // Clip a row start to the store size
    function automatic logic [PW-1:0] clip_pos(input logic [csrsd_pkg::RS_W-1:0] v);
        clip_pos = (32'(v) > MAX_NONZEROS) ? PW'(MAX_NONZEROS) : PW'(v);
    endfunction

    assign p_ok   = 32'(i_row_p) < MAX_ROWS;
    assign q_ok   = 32'(i_row_q) < MAX_ROWS;
    assign run    = (r_li < r_lend) && (r_mi < r_mend);
    assign col_eq = i_l_col == i_m_col;
    assign col_lt = i_l_col < i_m_col;

    // Sequence: fetch row starts, fetch row ends, merge, hand off
    always_comb begin
        n_state     = r_state;
        n_p_ok      = r_p_ok;
        n_q_ok      = r_q_ok;
        n_p1        = r_p1;
        n_q1        = r_q1;
        n_li        = r_li;
        n_lend      = r_lend;
        n_mi        = r_mi;
        n_mend      = r_mend;
        o_l_rs_addr = RW'(i_row_p);
        o_m_rs_addr = RW'(i_row_q);
        o_mac       = '0;
        o_done      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_p_ok      = p_ok;
                    n_q_ok      = q_ok;
                    n_p1        = RW'(32'(i_row_p) + 1);
                    n_q1        = RW'(32'(i_row_q) + 1);
                    o_mac.clear = 1'b1;
                    n_state     = ST_RS0;
                end
            end
            ST_RS0: begin
                o_l_rs_addr = r_p1;
                o_m_rs_addr = r_q1;
                n_li        = r_p_ok ? clip_pos(i_l_rs) : '0;
                n_mi        = r_q_ok ? clip_pos(i_m_rs) : '0;
                n_state     = ST_RS1;
            end
            ST_RS1: begin
                n_lend  = r_p_ok ? clip_pos(i_l_rs) : '0;
                n_mend  = r_q_ok ? clip_pos(i_m_rs) : '0;
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (run) begin
                    priority if (col_eq) begin
                        o_mac.fire = 1'b1;
                        n_li       = r_li + 1'b1;
                        n_mi       = r_mi + 1'b1;
                    end else if (col_lt) begin
                        n_li = r_li + 1'b1;
                    end else begin
                        n_mi = r_mi + 1'b1;
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Read the entries that the next cycle compares
    assign o_l_ent_addr = AW'(n_li);
    assign o_m_ent_addr = AW'(n_mi);
    assign o_busy       = r_state != ST_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_p_ok <= n_p_ok;
        r_q_ok <= n_q_ok;
        r_p1   <= n_p1;
        r_q1   <= n_q1;
        r_li   <= n_li;
        r_lend <= n_lend;
        r_mi   <= n_mi;
        r_mend <= n_mend;
    end

endmodule

[rtl/core/csr_sparse_row_dot_sddmm.sv]
`timescale 1ns / 1ps

// Channel   Dir  Handshake        Word
// i_in      in   valid / ready    command, slot, column, value, row_start, row_p, row_q
// o_out     out  valid / ready    dot_product, saturated
//
// Loads are taken back to back while no query is in progress.
// A query reads both row starts, then both row ends, then takes S merge steps (at most the
// sum of both row lengths), with one read of each entry store per step.
// The result sits in an output register; loads are taken while it waits.
// Reset clears control and the accumulator; the stores hold nothing defined until loaded.
module csr_sparse_row_dot_sddmm #(
    parameter int MAX_ROWS     = 64,
    parameter int MAX_NONZEROS = 1024,
    parameter int MAX_COLUMNS  = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    csrsd_in_if.sink           i_in,
    csrsd_out_if.source        o_out
);

    localparam int AW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int VW = csrsd_pkg::VAL_W;
    localparam int EW = csrsd_pkg::ENTRY_W;
    localparam int SW = csrsd_pkg::RS_W;

    logic          accept, ent_ok, rs_ok, busy, done, out_free;
    logic          l_ent_we, m_ent_we, l_rs_we, m_rs_we, query;
    logic [AW-1:0] ent_waddr, l_ent_raddr, m_ent_raddr;
    logic [RW-1:0] rs_waddr, l_rs_raddr, m_rs_raddr;
    logic [EW-1:0] ent_wdata, l_ent_rdata, m_ent_rdata;
    logic [SW-1:0] l_rs_rdata, m_rs_rdata;

    logic signed [csrsd_pkg::ACC_W-1:0] acc;
    logic                               sat;
    csrsd_pkg::t_mac_ctl                mac_ctl;

    logic                 r_out_valid;
    csrsd_pkg::t_out_word r_out;

    // Decode the accepted word
    assign accept   = i_in.valid && i_in.ready;
    assign ent_ok   = (32'(i_in.data.slot) < MAX_NONZEROS)
                   && (32'(i_in.data.column) < MAX_COLUMNS);
    assign rs_ok    = 32'(i_in.data.slot) <= MAX_ROWS;
    assign l_ent_we = accept && ent_ok && (i_in.data.command == csrsd_pkg::CMD_LOAD_L_ENTRY);
    assign m_ent_we = accept && ent_ok && (i_in.data.command == csrsd_pkg::CMD_LOAD_M_ENTRY);
    assign l_rs_we  = accept && rs_ok && (i_in.data.command == csrsd_pkg::CMD_LOAD_L_START);
    assign m_rs_we  = accept && rs_ok && (i_in.data.command == csrsd_pkg::CMD_LOAD_M_START);
    assign query    = accept && (i_in.data.command == csrsd_pkg::CMD_QUERY);

    assign ent_waddr = AW'(i_in.data.slot);
    assign rs_waddr  = RW'(i_in.data.slot);
    assign ent_wdata = {i_in.data.column, i_in.data.value};

    // Entry stores and row start tables
    csrsd_ram #(.WIDTH(EW), .DEPTH(MAX_NONZEROS)) u_l_ent (
        .i_clk   (i_clk),
        .i_we    (l_ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (l_ent_raddr),
        .o_rdata (l_ent_rdata)
    );

    csrsd_ram #(.WIDTH(EW), .DEPTH(MAX_NONZEROS)) u_m_ent (
        .i_clk   (i_clk),
        .i_we    (m_ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (m_ent_raddr),
        .o_rdata (m_ent_rdata)
    );

    csrsd_ram #(.WIDTH(SW), .DEPTH(MAX_ROWS + 1)) u_l_rs (
        .i_clk   (i_clk),
        .i_we    (l_rs_we),
        .i_waddr (rs_waddr),
        .i_wdata (i_in.data.row_start),
        .i_raddr (l_rs_raddr),
        .o_rdata (l_rs_rdata)
    );

    csrsd_ram #(.WIDTH(SW), .DEPTH(MAX_ROWS + 1)) u_m_rs (
        .i_clk   (i_clk),
        .i_we    (m_rs_we),
        .i_waddr (rs_waddr),
        .i_wdata (i_in.data.row_start),
        .i_raddr (m_rs_raddr),
        .o_rdata (m_rs_rdata)
    );

    // Merge walker
    csrsd_walk #(.MAX_ROWS(MAX_ROWS), .MAX_NONZEROS(MAX_NONZEROS)) u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (query),
        .i_row_p      (i_in.data.row_p),
        .i_row_q      (i_in.data.row_q),
        .i_l_rs       (l_rs_rdata),
        .i_m_rs       (m_rs_rdata),
        .i_l_col      (l_ent_rdata[EW-1:VW]),
        .i_m_col      (m_ent_rdata[EW-1:VW]),
        .i_out_free   (out_free),
        .o_busy       (busy),
        .o_done       (done),
        .o_l_rs_addr  (l_rs_raddr),
        .o_m_rs_addr  (m_rs_raddr),
        .o_l_ent_addr (l_ent_raddr),
        .o_m_ent_addr (m_ent_raddr),
        .o_mac        (mac_ctl)
    );

    // Multiply-accumulate
    csrsd_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_l_val (signed'(l_ent_rdata[VW-1:0])),
        .i_m_val (signed'(m_ent_rdata[VW-1:0])),
        .o_acc   (acc),
        .o_sat   (sat)
    );

    // Hold the result word until taken
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (done) begin
            r_out.dot_product <= acc;
            r_out.saturated   <= sat;
        end
    end

    assign i_in.ready  = !busy;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

[rtl/core/csrsd_chk.sv]
`timescale 1ns / 1ps
`include "csr_sparse_row_dot_sddmm_macros.svh"

module csrsd_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [csrsd_pkg::CMD_W-1:0]    i_in_cmd,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  csrsd_pkg::t_out_word           i_out_data
);

    // A waiting result word stays offered
    `CSRSD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result word dropped")

    // A query keeps the block busy in the next cycle
    `CSRSD_ASSERT_NEXT(a_query_busy, i_in_valid && i_in_ready && (i_in_cmd == csrsd_pkg::CMD_QUERY), !i_in_ready, "word taken during a query")

    // A load never produces a result word
    `CSRSD_ASSERT_NEXT(a_load_silent, i_in_valid && i_in_ready && !i_out_valid && (i_in_cmd != csrsd_pkg::CMD_QUERY), !i_out_valid, "result word after a load")

    // A waiting result word holds its payload
    `CSRSD_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_data), "result word changed while waiting")

endmodule

bind csr_sparse_row_dot_sddmm csrsd_chk u_csrsd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.data.command),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

[verif/csrsd_dot_checker.sv]
`timescale 1ns / 1ps

// Watch both channels, predict each query's dot product and compare in order.
module csrsd_dot_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    csrsd_in_if   i_cmd,
    csrsd_out_if  i_res,
    output int    o_errors,
    output int    o_pending,
    output int    o_results,
    output int    o_clipped
);
    import csrsd_pkg::*;

    localparam int NUM_ROWS     = 64;
    localparam int NUM_SLOTS    = 1024;
    localparam int REPORT_LIMIT = 10;
    localparam longint SUM_HI   = longint'(ACC_MAX);
    localparam longint SUM_LO   = longint'(ACC_MIN);

    // Shadow copies of both CSR matrices
    logic [COL_W-1:0]        l_cols   [NUM_SLOTS];
    logic signed [VAL_W-1:0] l_vals   [NUM_SLOTS];
    logic [RS_W-1:0]         l_starts [NUM_ROWS+1];
    logic [COL_W-1:0]        m_cols   [NUM_SLOTS];
    logic signed [VAL_W-1:0] m_vals   [NUM_SLOTS];
    logic [RS_W-1:0]         m_starts [NUM_ROWS+1];

    t_out_word expected_sums [$];

    int error_count   = 0;
    int pending_count = 0;
    int result_count  = 0;
    int clipped_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;
    assign o_results = result_count;
    assign o_clipped = clipped_count;

    // Clip a row boundary to the end of the entry store
    function automatic int clip_pos(input logic [RS_W-1:0] pos);
        return (pos > NUM_SLOTS) ? NUM_SLOTS : int'(pos);
    endfunction

    // Two-pointer merge of L row p with M row q, saturating after every add
    function automatic t_out_word merged_dot(input logic [ROW_W-1:0] p,
                                             input logic [ROW_W-1:0] q);
        int        li, l_end, mi, m_end, pi, qi;
        longint    sum;
        logic      clip;
        t_out_word res;
        pi    = p;
        qi    = q;
        li    = clip_pos(l_starts[pi]);
        l_end = clip_pos(l_starts[pi+1]);
        mi    = clip_pos(m_starts[qi]);
        m_end = clip_pos(m_starts[qi+1]);
        sum   = 0;
        clip  = 1'b0;
        while (li < l_end && mi < m_end) begin
            if (l_cols[li] == m_cols[mi]) begin
                sum += longint'(l_vals[li]) * longint'(m_vals[mi]);
                if (sum > SUM_HI) begin
                    sum  = SUM_HI;
                    clip = 1'b1;
                end else if (sum < SUM_LO) begin
                    sum  = SUM_LO;
                    clip = 1'b1;
                end
                li++;
                mi++;
            end else if (l_cols[li] < m_cols[mi]) begin
                li++;
            end else begin
                mi++;
            end
        end
        res.dot_product = sum[ACC_W-1:0];
        res.saturated   = clip;
        return res;
    endfunction

    // Apply one accepted command word: update the shadow stores or queue a query's expected result
    task automatic apply_word(input t_in_word w);
        case (w.command)
            CMD_LOAD_L_ENTRY: begin
                if (w.slot < NUM_SLOTS) begin
                    l_cols[w.slot] = w.column;
                    l_vals[w.slot] = w.value;
                end
            end
            CMD_LOAD_M_ENTRY: begin
                if (w.slot < NUM_SLOTS) begin
                    m_cols[w.slot] = w.column;
                    m_vals[w.slot] = w.value;
                end
            end
            CMD_LOAD_L_START: begin
                if (w.slot <= NUM_ROWS) l_starts[w.slot] = w.row_start;
            end
            CMD_LOAD_M_START: begin
                if (w.slot <= NUM_ROWS) m_starts[w.slot] = w.row_start;
            end
            CMD_QUERY: begin
                expected_sums.push_back(merged_dot(w.row_p, w.row_q));
                pending_count++;
            end
            default: ;
        endcase
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
    endtask

    // Check results before taking new commands: a result never belongs to
    // a query accepted on the same edge
    always @(posedge i_clk) begin : watch
        t_out_word want;
        t_out_word got;
        if (i_rst_n) begin
            if (i_res.valid && i_res.ready) begin
                got = i_res.data;
                result_count++;
                if (got.saturated) clipped_count++;
                if (expected_sums.size() == 0) begin
                    flag_error($sformatf("unexpected result word: dot %0d sat %0b",
                                         got.dot_product, got.saturated));
                end else begin
                    want = expected_sums.pop_front();
                    pending_count--;
                    if (got.dot_product !== want.dot_product ||
                        got.saturated !== want.saturated) begin
                        flag_error($sformatf(
                            "result mismatch: expected dot %0d sat %0b, got dot %0d sat %0b",
                            want.dot_product, want.saturated,
                            got.dot_product, got.saturated));
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) apply_word(i_cmd.data);
        end
    end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import csrsd_pkg::*;

    localparam int NUM_ROWS     = 64;
    localparam int NUM_SLOTS    = 1024;
    localparam int NUM_COLS     = 1024;
    localparam int TOTAL_ITEMS  = 1350;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 64;
    localparam int SAT_LEN      = 516;
    localparam int SAT_TAIL     = 6;
    localparam int SIDE_L       = 0;
    localparam int SIDE_M       = 1;

    // Command codes the block leaves unused
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_e;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    csrsd_in_if  cmd_ch ();
    csrsd_out_if res_ch ();

    int errors, pending, results, clipped;

    csr_sparse_row_dot_sddmm uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    csrsd_dot_checker u_dot_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd_ch),
        .i_res     (res_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_results (results),
        .o_clipped (clipped)
    );

    always #4 i_clk = ~i_clk;

    // Track which stores have been written, so no query reads an empty entry
    bit              ent_seen   [2][NUM_SLOTS];
    bit              start_seen [2][NUM_ROWS+1];
    logic [RS_W-1:0] start_tab  [2][NUM_ROWS+1];

    int burst_left  = 0;
    bit steady      = 1'b0;
    int n_words     = 0;
    int n_queries   = 0;
    int n_builds    = 0;

    function automatic t_in_word rand_word();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(t_in_word)-1:0];
    endfunction

    function automatic int rand_value();
        case ($urandom_range(0, 7))
            0:       return -32768;
            1:       return 32767;
            2:       return -1;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic int clip_slot(input logic [RS_W-1:0] pos);
        return (pos > NUM_SLOTS) ? NUM_SLOTS : int'(pos);
    endfunction

    // A row may be queried once both bounds and every entry between are set
    function automatic bit span_ready(input int side, input int row);
        int lo, hi;
        if (!start_seen[side][row] || !start_seen[side][row+1]) return 1'b0;
        lo = clip_slot(start_tab[side][row]);
        hi = clip_slot(start_tab[side][row+1]);
        for (int i = lo; i < hi; i++)
            if (!ent_seen[side][i]) return 1'b0;
        return 1'b1;
    endfunction

    // Record what an accepted word did to the stores
    task automatic note_accepted(input t_in_word w);
        n_words++;
        case (w.command)
            CMD_LOAD_L_ENTRY, CMD_LOAD_M_ENTRY: begin
                if (w.slot < NUM_SLOTS) begin
                    ent_seen[(w.command == CMD_LOAD_M_ENTRY) ? SIDE_M : SIDE_L][w.slot] = 1'b1;
                end
            end
            CMD_LOAD_L_START, CMD_LOAD_M_START: begin
                if (w.slot <= NUM_ROWS) begin
                    start_tab[(w.command == CMD_LOAD_M_START) ? SIDE_M : SIDE_L][w.slot] =
                        w.row_start;
                    start_seen[(w.command == CMD_LOAD_M_START) ? SIDE_M : SIDE_L][w.slot] =
                        1'b1;
                end
            end
            CMD_QUERY: begin
                n_queries++;
            end
            default: ;
        endcase
    endtask

    // Drive one word in bursts, with random gaps between bursts unless steady; return once it is taken
    task automatic send_word(input t_in_word w);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!steady) begin
                @(negedge i_clk);
                cmd_ch.valid <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= w;
        do @(posedge i_clk); while (!cmd_ch.ready);
        burst_left--;
        note_accepted(w);
    endtask

    task automatic send_entry(input int side, input int slot, input int col, input int val);
        t_in_word w;
        w         = rand_word();
        w.command = (side == SIDE_M) ? CMD_LOAD_M_ENTRY : CMD_LOAD_L_ENTRY;
        w.slot    = slot[SLOT_W-1:0];
        w.column  = col[COL_W-1:0];
        w.value   = val[VAL_W-1:0];
        send_word(w);
    endtask

    task automatic send_start(input int side, input int row, input int start);
        t_in_word w;
        w           = rand_word();
        w.command   = (side == SIDE_M) ? CMD_LOAD_M_START : CMD_LOAD_L_START;
        w.slot      = row[SLOT_W-1:0];
        w.row_start = start[RS_W-1:0];
        send_word(w);
    endtask

    task automatic send_query(input int p, input int q);
        t_in_word w;
        w         = rand_word();
        w.command = CMD_QUERY;
        w.row_p   = p[ROW_W-1:0];
        w.row_q   = q[ROW_W-1:0];
        send_word(w);
    endtask

    // Query mostly inside the freshly built windows; skip if nothing is safe
    task automatic issue_query(input int lr0, input int lr1, input int mr0, input int mr1);
        int p, q;
        for (int t = 0; t < 32; t++) begin
            p = ($urandom_range(0, 3) != 0) ? $urandom_range(lr0, lr1)
                                            : $urandom_range(0, NUM_ROWS - 1);
            q = ($urandom_range(0, 3) != 0) ? $urandom_range(mr0, mr1)
                                            : $urandom_range(0, NUM_ROWS - 1);
            if (span_ready(SIDE_L, p) && span_ready(SIDE_M, q)) begin
                send_query(p, q);
                return;
            end
        end
    endtask

    // Stray words: unused codes, out-of-range loads, a lone overwrite
    task automatic send_noise();
        t_in_word w;
        w = rand_word();
        case ($urandom_range(0, 3))
            0: w.command = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            1: begin
                w.command = ($urandom_range(0, 1) != 0) ? CMD_LOAD_M_ENTRY : CMD_LOAD_L_ENTRY;
                w.slot    = SLOT_W'($urandom_range(NUM_SLOTS, 2047));
            end
            2: begin
                w.command = ($urandom_range(0, 1) != 0) ? CMD_LOAD_M_START : CMD_LOAD_L_START;
                w.slot    = SLOT_W'($urandom_range(NUM_ROWS + 1, 2047));
            end
            default: begin
                w.command = ($urandom_range(0, 1) != 0) ? CMD_LOAD_M_ENTRY : CMD_LOAD_L_ENTRY;
                w.slot    = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
            end
        endcase
        send_word(w);
    endtask

    // Load rows r0..r1 of one matrix as a contiguous CSR block
    task automatic build_rows(input int side, input int r0, input int r1,
                              input int col_base, input int max_len);
        int lens [NUM_ROWS];
        int total, pos, cum, c, col;
        bit jumbled;
        total = 0;
        for (int r = r0; r <= r1; r++) begin
            lens[r] = $urandom_range(0, max_len);
            total  += lens[r];
        end
        pos = $urandom_range(0, NUM_SLOTS - total);
        cum = pos;
        n_builds++;
        // columns climb with repeats allowed; a few rows get them shuffled
        for (int r = r0; r <= r1; r++) begin
            jumbled = ($urandom_range(0, 9) == 0);
            c = col_base + $urandom_range(0, 3);
            for (int k = 0; k < lens[r]; k++) begin
                col = jumbled ? col_base + $urandom_range(0, 31) : c;
                if (col > NUM_COLS - 1) col = NUM_COLS - 1;
                send_entry(side, cum + k, col, rand_value());
                c += $urandom_range(0, 3);
            end
            cum += lens[r];
        end
        // point the row starts at the new block, now and then at garbage
        cum = pos;
        for (int r = r0; r <= r1 + 1; r++) begin
            if ($urandom_range(0, 15) == 0) send_start(side, r, $urandom_range(0, 2047));
            else send_start(side, r, cum);
            if (r <= r1) cum += lens[r];
        end
    endtask

    // Receiver stall pattern, switching mode every so often
    rx_mode_e rx_mode  = RX_OPEN;
    int       rx_left  = 0;
    int       rx_tick  = 0;

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_left == 0) begin
                rx_mode = rx_mode_e'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 160);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                RX_OPEN:   res_ch.ready <= 1'b1;
                RX_COIN:   res_ch.ready <= ($urandom_range(0, 1) != 0);
                RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
                default:   res_ch.ready <= (rx_tick % 3 != 0);
            endcase
        end
    end

    // Watchdog: end the run if no word moves for too long
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending);
            $display("** csr_sparse_row_dot_sddmm: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        int lr0, lr1, mr0, mr1, col_base, max_len;
        bit sat_low;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Unused codes and out-of-range loads: all dropped
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) begin
            send_noise_code : begin
                t_in_word w;
                w = rand_word();
                w.command = c[CMD_W-1:0];
                send_word(w);
            end
        end
        send_entry(SIDE_L, NUM_SLOTS, 3, 77);
        send_entry(SIDE_M, 2047, 3, -77);
        send_start(SIDE_L, NUM_ROWS + 1, 0);
        send_start(SIDE_M, 2047, 0);

        // Entries at the top of the store, extreme values, repeated columns
        send_entry(SIDE_L, 1020, 5, 32767);
        send_entry(SIDE_L, 1021, 9, -32768);
        send_entry(SIDE_L, 1022, 9, 1);
        send_entry(SIDE_L, 1023, NUM_COLS - 1, -1);
        send_entry(SIDE_M, 1020, 0, -32768);
        send_entry(SIDE_M, 1021, 9, 32767);
        send_entry(SIDE_M, 1022, NUM_COLS - 1, -1);
        send_entry(SIDE_M, 1023, NUM_COLS - 1, 5);

        // L row 62 ends past the store (clipped), L row 63 ends below its start; M row 63 is empty
        send_start(SIDE_L, 62, 1020);
        send_start(SIDE_L, 63, 2047);
        send_start(SIDE_L, 64, 0);
        send_start(SIDE_M, 62, 1020);
        send_start(SIDE_M, 63, NUM_SLOTS);
        send_start(SIDE_M, 64, NUM_SLOTS);
        send_query(62, 62);
        send_query(63, 63);
        send_query(62, 63);
        send_query(63, 62);

        // Long row 0 in both: saturate high or low, then back off after clipping
        sat_low = ($urandom_range(0, 1) != 0);
        send_start(SIDE_L, 0, 0);
        send_start(SIDE_L, 1, SAT_LEN + SAT_TAIL);
        send_start(SIDE_M, 0, 0);
        send_start(SIDE_M, 1, SAT_LEN + SAT_TAIL);
        for (int i = 0; i < SAT_LEN + SAT_TAIL; i++)
            send_entry(SIDE_L, i, i, (i < SAT_LEN) ? -32768 : 32767);
        for (int i = 0; i < SAT_LEN + SAT_TAIL; i++)
            send_entry(SIDE_M, i, i, sat_low ? 32767 : -32768);
        send_query(0, 0);

        // Random rounds: build row windows, then query into them
        while (n_words < TOTAL_ITEMS) begin
            steady = ($urandom_range(0, 3) == 0);
            lr0 = $urandom_range(0, NUM_ROWS - 1);
            lr1 = lr0 + $urandom_range(0, 11);
            if (lr1 > NUM_ROWS - 1) lr1 = NUM_ROWS - 1;
            mr0 = $urandom_range(0, NUM_ROWS - 1);
            mr1 = mr0 + $urandom_range(0, 11);
            if (mr1 > NUM_ROWS - 1) mr1 = NUM_ROWS - 1;
            col_base = $urandom_range(0, NUM_COLS - 1);
            max_len  = ($urandom_range(0, 7) == 0) ? 12 : 5;
            if ($urandom_range(0, 3) != 0) build_rows(SIDE_L, lr0, lr1, col_base, max_len);
            if ($urandom_range(0, 3) != 0) build_rows(SIDE_M, mr0, mr1, col_base, max_len);
            repeat ($urandom_range(6, 20)) begin
                if ($urandom_range(0, 7) == 0) send_noise();
                else issue_query(lr0, lr1, mr0, mr1);
            end
        end

        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d command words (%0d queries, %0d row windows built).",
                 n_words, n_queries, n_builds);
        $display("Checked %0d dot products, %0d saturated; %0d mismatches.",
                 results, clipped, errors);
        if (errors == 0 && pending == 0)
            $display("** csr_sparse_row_dot_sddmm: PASSED **");
        else
            $display("** csr_sparse_row_dot_sddmm: FAILED **");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/csrsd_pkg.sv
rtl/core/csrsd_if.sv
rtl/core/csrsd_ram.sv
rtl/core/csrsd_mac.sv
rtl/core/csrsd_walk.sv
rtl/core/csr_sparse_row_dot_sddmm.sv
rtl/core/csrsd_chk.sv
verif/csrsd_dot_checker.sv
verif/tb.sv
